### src/sts_pkg.sv
// ---------------------------------------------------------------------------
// sts_pkg
// Shared types, token class codes and the keyword table of the token scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int unsigned RES_MAX    = 4;
  localparam int unsigned KW_COUNT   = 67;
  localparam int unsigned KW_LEN_MAX = 9;
  localparam int unsigned KEY_BITS   = 8 * KW_LEN_MAX;

  typedef enum logic [4:0] {
    CLS_IDENT  = 5'd0,
    CLS_KW     = 5'd1,
    CLS_INT    = 5'd2,
    CLS_DEC    = 5'd3,
    CLS_STR    = 5'd4,
    CLS_LPAREN = 5'd5,
    CLS_RPAREN = 5'd6,
    CLS_COMMA  = 5'd7,
    CLS_SEMI   = 5'd8,
    CLS_DOT    = 5'd9,
    CLS_PLUS   = 5'd10,
    CLS_MINUS  = 5'd11,
    CLS_STAR   = 5'd12,
    CLS_SLASH  = 5'd13,
    CLS_PCT    = 5'd14,
    CLS_EQ     = 5'd15,
    CLS_LE     = 5'd16,
    CLS_NE     = 5'd17,
    CLS_LT     = 5'd18,
    CLS_GE     = 5'd19,
    CLS_GT     = 5'd20,
    CLS_EOF    = 5'd21,
    CLS_ERR    = 5'd22
  } tok_class_e;

  typedef struct packed {
    tok_class_e  cls;
    logic [6:0]  kw;
    logic [15:0] off;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        esc;
    logic [7:0]  bad;
  } tok_rec_t;

  localparam logic [KEY_BITS-1:0] KW_WORDS [KW_COUNT] = '{
    "SELECT", "FROM", "WHERE", "AS", "DISTINCT", "ALL", "AND", "OR", "NOT",
    "IN", "BETWEEN", "IS", "NULL", "LIKE",
    "JOIN", "INNER", "LEFT", "RIGHT", "OUTER", "CROSS", "ON",
    "GROUP", "BY", "HAVING", "ORDER", "ASC", "DESC", "LIMIT", "OFFSET",
    "TRUE", "FALSE", "COUNT", "SUM", "AVG", "MIN", "MAX",
    "UPPER", "LOWER", "LENGTH", "TRIM", "ABS", "ROUND",
    "COALESCE", "CONCAT", "SUBSTRING",
    "LOAD", "SHOW", "TABLES", "DESCRIBE", "CREATE", "INDEX", "DROP", "INDEXES",
    "TABLE", "INSERT", "INTO", "VALUES", "DELETE",
    "ALTER", "COLUMN", "RENAME", "TO", "ADD",
    "UPDATE", "SET", "EXPORT", "FORMAT"
  };

  function automatic logic [6:0] kw_find(input logic [KEY_BITS-1:0] key);
    logic [6:0] r;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (key == KW_WORDS[i]) r = 7'(i + 1);
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c inside {["a":"z"]}) ? c - 8'd32 : c;
  endfunction

endpackage

`default_nettype wire

### src/sts_outq.sv
// ---------------------------------------------------------------------------
// sts_outq
// Result buffer: holds the records of one byte and hands them out in order.
// ---------------------------------------------------------------------------
`default_nettype none

module sts_outq
  import sts_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire logic [2:0] cnt_i,
  input  wire tok_rec_t recs_i [RES_MAX],
  output logic          space_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output tok_rec_t      rec_o,
  output logic          last_o
);

  tok_rec_t   recs_q [RES_MAX];
  logic [2:0] cnt_q;
  logic [2:0] rd_q;
  logic       pop;

  assign valid_o = (rd_q != cnt_q);
  assign pop     = valid_o && ready_i;
  assign last_o  = ((rd_q + 3'd1) == cnt_q);
  assign space_o = !valid_o || (pop && last_o);
  assign rec_o   = recs_q[rd_q[1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (push_i) begin
      cnt_q <= cnt_i;
      rd_q  <= '0;
    end else if (pop) begin
      rd_q <= rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) recs_q <= recs_i;
  end

endmodule

`default_nettype wire

### src/sql_token_scanner_core.sv
// ---------------------------------------------------------------------------
// sql_token_scanner_core
// Streaming SQL tokenizer, one query byte per transfer, token records out.
// ---------------------------------------------------------------------------
// A byte is taken while the buffer has space; its records (up to four, one byte
// of lookahead lets a byte close a pending token, a dot and its own token, and
// the end-of-text flush plus eof) are written to a result buffer and leave one
// per cycle while the receiver is ready. A byte that yields at most one record
// sustains one byte per cycle on that condition; one with more records holds
// the input until its last is taken. Positions count in POS_BITS bits and saturate.
`default_nettype none

module sql_token_scanner_core
  import sts_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        text_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       token_class_o,
  output logic [6:0]       keyword_index_o,
  output logic [15:0]      start_offset_o,
  output logic [15:0]      token_length_o,
  output logic [15:0]      start_line_o,
  output logic [15:0]      start_column_o,
  output logic             has_escape_o,
  output logic [7:0]       bad_char_o,
  output logic             run_end_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_MINUS, M_COMMENT, M_IDENT, M_INT, M_INTDOT, M_DEC,
    M_STR, M_STRQ, M_QID, M_LT, M_GT, M_BANG
  } mode_e;

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t PosMax = {POS_BITS{1'b1}};
  localparam pos_t PosOne = POS_BITS'(1);
  localparam pos_t PosTwo = POS_BITS'(2);
  localparam pos_t KwMax  = POS_BITS'(KW_LEN_MAX);

  function automatic pos_t sat_inc(input pos_t v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  function automatic pos_t sat_add2(input pos_t v);
    return (v >= PosMax - PosOne) ? PosMax : v + PosTwo;
  endfunction

  function automatic tok_rec_t mk_rec(input tok_class_e cls, input logic [6:0] kw,
                                      input pos_t off, input pos_t len, input pos_t line,
                                      input pos_t col, input logic esc,
                                      input logic [7:0] bad);
    tok_rec_t r;
    r.cls  = cls;
    r.kw   = kw;
    r.off  = 16'(off);
    r.len  = 16'(len);
    r.line = 16'(line);
    r.col  = 16'(col);
    r.esc  = esc;
    r.bad  = bad;
    return r;
  endfunction

  mode_e               mode_q, mode_d;
  pos_t                off_q, off_d, line_q, line_d, col_q, col_d;
  pos_t                ts_off_q, ts_off_d, ts_line_q, ts_line_d, ts_col_q, ts_col_d;
  pos_t                tlen_q, tlen_d;
  pos_t                pv_off_q, pv_off_d, pv_line_q, pv_line_d, pv_col_q, pv_col_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                esc_q, esc_d, halt_q, halt_d;

  tok_rec_t   recs [RES_MAX];
  logic [2:0] nres;
  logic       in_fire;
  logic       space;
  tok_rec_t   orec;
  logic       olast;

  assign in_ready_o = space;
  assign in_fire    = in_valid_i && space;

  always_comb begin
    logic [7:0] c;
    logic       last;
    logic       start;
    logic [6:0] kw;
    c      = char_in_i;
    last   = text_end_i;
    start  = 1'b0;
    kw     = '0;
    nres   = '0;
    for (int i = 0; i < RES_MAX; i++) recs[i] = '0;
    mode_d    = mode_q;
    off_d     = off_q;
    line_d    = line_q;
    col_d     = col_q;
    ts_off_d  = ts_off_q;
    ts_line_d = ts_line_q;
    ts_col_d  = ts_col_q;
    tlen_d    = tlen_q;
    pv_off_d  = pv_off_q;
    pv_line_d = pv_line_q;
    pv_col_d  = pv_col_q;
    key_d     = key_q;
    esc_d     = esc_q;
    halt_d    = halt_q;

    if (in_fire) begin
      if (halt_q) begin
        if (last) begin
          mode_d = M_IDLE; off_d = '0; line_d = PosOne; col_d = PosOne;
          ts_off_d = '0; ts_line_d = PosOne; ts_col_d = PosOne; tlen_d = '0;
          esc_d = 1'b0; halt_d = 1'b0;
          pv_off_d = '0; pv_line_d = PosOne; pv_col_d = PosOne;
        end
      end else begin
        case (mode_q)
          M_MINUS: begin
            if (c == "-") mode_d = M_COMMENT;
            else begin
              tlen_d = PosOne;
              recs[nres[1:0]] = mk_rec(CLS_MINUS, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_COMMENT: begin
            if (c == 8'h0A) mode_d = M_IDLE;
          end
          M_IDENT: begin
            if (is_word(c)) begin
              if (tlen_q < KwMax) key_d = {key_q[KEY_BITS-9:0], to_upper(c)};
              tlen_d = sat_inc(tlen_q);
            end else begin
              kw = (tlen_d != '0 && tlen_d <= KwMax) ? kw_find(key_d) : '0;
              recs[nres[1:0]] = mk_rec((kw != '0) ? CLS_KW : CLS_IDENT, kw, ts_off_d,
                                       tlen_d, ts_line_d, ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit(c)) tlen_d = sat_inc(tlen_q);
            else if (c == ".") mode_d = M_INTDOT;
            else begin
              recs[nres[1:0]] = mk_rec(CLS_INT, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_INTDOT: begin
            if (is_digit(c)) begin
              tlen_d = sat_add2(tlen_q);
              mode_d = M_DEC;
            end else begin
              recs[nres[1:0]] = mk_rec(CLS_INT, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              recs[nres[1:0]] = mk_rec(CLS_DOT, '0, pv_off_q, PosOne, pv_line_q,
                                       pv_col_q, 1'b0, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_DEC: begin
            if (is_digit(c)) tlen_d = sat_inc(tlen_q);
            else begin
              recs[nres[1:0]] = mk_rec(CLS_DEC, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_STR: begin
            if (c == "'") mode_d = M_STRQ;
            else tlen_d = sat_inc(tlen_q);
          end
          M_STRQ: begin
            if (c == "'") begin
              tlen_d = sat_add2(tlen_q);
              esc_d  = 1'b1;
              mode_d = M_STR;
            end else begin
              recs[nres[1:0]] = mk_rec(CLS_STR, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_QID: begin
            if (c == "\"") begin
              recs[nres[1:0]] = mk_rec(CLS_IDENT, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              mode_d = M_IDLE;
            end else tlen_d = sat_inc(tlen_q);
          end
          M_LT: begin
            if (c == "=" || c == ">") begin
              tlen_d = PosTwo;
              recs[nres[1:0]] = mk_rec((c == "=") ? CLS_LE : CLS_NE, '0, ts_off_d,
                                       tlen_d, ts_line_d, ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              mode_d = M_IDLE;
            end else begin
              tlen_d = PosOne;
              recs[nres[1:0]] = mk_rec(CLS_LT, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_GT: begin
            if (c == "=") begin
              tlen_d = PosTwo;
              recs[nres[1:0]] = mk_rec(CLS_GE, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              mode_d = M_IDLE;
            end else begin
              tlen_d = PosOne;
              recs[nres[1:0]] = mk_rec(CLS_GT, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
              start = 1'b1;
            end
          end
          M_BANG: begin
            if (c == "=") begin
              tlen_d = PosTwo;
              recs[nres[1:0]] = mk_rec(CLS_NE, '0, ts_off_d, tlen_d, ts_line_d,
                                       ts_col_d, esc_d, '0);
              nres = nres + 3'd1;
            end else begin
              recs[nres[1:0]] = mk_rec(CLS_ERR, '0, ts_off_d, PosOne, ts_line_d,
                                       ts_col_d, 1'b0, "!");
              nres = nres + 3'd1;
              halt_d = 1'b1;
            end
            mode_d = M_IDLE;
          end
          default: start = 1'b1;
        endcase

        if (start) begin
          mode_d = M_IDLE;
          if (is_space(c)) begin
            mode_d = M_IDLE;
          end else if (is_alpha(c) || c == "_") begin
            ts_off_d = off_q; ts_line_d = line_q; ts_col_d = col_q;
            esc_d = 1'b0; tlen_d = PosOne;
            key_d = {{(KEY_BITS-8){1'b0}}, to_upper(c)};
            mode_d = M_IDENT;
          end else if (is_digit(c)) begin
            ts_off_d = off_q; ts_line_d = line_q; ts_col_d = col_q;
            esc_d = 1'b0; tlen_d = PosOne;
            mode_d = M_INT;
          end else if (c == "'" || c == "\"") begin
            ts_off_d = sat_inc(off_q); ts_line_d = line_q; ts_col_d = col_q;
            esc_d = 1'b0; tlen_d = '0;
            mode_d = (c == "'") ? M_STR : M_QID;
          end else if (c == "-" || c == "<" || c == ">" || c == "!") begin
            ts_off_d = off_q; ts_line_d = line_q; ts_col_d = col_q;
            esc_d = 1'b0; tlen_d = '0;
            case (c)
              "-":     mode_d = M_MINUS;
              "<":     mode_d = M_LT;
              ">":     mode_d = M_GT;
              default: mode_d = M_BANG;
            endcase
          end else begin
            case (c)
              "(": recs[nres[1:0]] = mk_rec(CLS_LPAREN, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              ")": recs[nres[1:0]] = mk_rec(CLS_RPAREN, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              ",": recs[nres[1:0]] = mk_rec(CLS_COMMA, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              ";": recs[nres[1:0]] = mk_rec(CLS_SEMI, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              ".": recs[nres[1:0]] = mk_rec(CLS_DOT, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              "+": recs[nres[1:0]] = mk_rec(CLS_PLUS, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              "*": recs[nres[1:0]] = mk_rec(CLS_STAR, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              "/": recs[nres[1:0]] = mk_rec(CLS_SLASH, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              "%": recs[nres[1:0]] = mk_rec(CLS_PCT, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              "=": recs[nres[1:0]] = mk_rec(CLS_EQ, '0, off_q, PosOne, line_q,
                                            col_q, 1'b0, '0);
              default: begin
                recs[nres[1:0]] = mk_rec(CLS_ERR, '0, off_q, PosOne, line_q,
                                         col_q, 1'b0, c);
                halt_d = 1'b1;
              end
            endcase
            nres = nres + 3'd1;
          end
        end

        pv_off_d  = off_q;
        pv_line_d = line_q;
        pv_col_d  = col_q;
        off_d     = sat_inc(off_q);
        if (c == 8'h0A) begin
          line_d = sat_inc(line_q);
          col_d  = PosOne;
        end else begin
          col_d = sat_inc(col_q);
        end

        if (last) begin
          if (!halt_d) begin
            case (mode_d)
              M_MINUS, M_LT, M_GT: begin
                tlen_d = PosOne;
                recs[nres[1:0]] = mk_rec((mode_d == M_MINUS) ? CLS_MINUS :
                                         (mode_d == M_LT) ? CLS_LT : CLS_GT, '0,
                                         ts_off_d, tlen_d, ts_line_d, ts_col_d, esc_d, '0);
                nres = nres + 3'd1;
              end
              M_IDENT: begin
                kw = (tlen_d != '0 && tlen_d <= KwMax) ? kw_find(key_d) : '0;
                recs[nres[1:0]] = mk_rec((kw != '0) ? CLS_KW : CLS_IDENT, kw, ts_off_d,
                                         tlen_d, ts_line_d, ts_col_d, esc_d, '0);
                nres = nres + 3'd1;
              end
              M_INT, M_DEC: begin
                recs[nres[1:0]] = mk_rec((mode_d == M_INT) ? CLS_INT : CLS_DEC, '0,
                                         ts_off_d, tlen_d, ts_line_d, ts_col_d, esc_d, '0);
                nres = nres + 3'd1;
              end
              M_INTDOT: begin
                recs[nres[1:0]] = mk_rec(CLS_INT, '0, ts_off_d, tlen_d, ts_line_d,
                                         ts_col_d, esc_d, '0);
                nres = nres + 3'd1;
                recs[nres[1:0]] = mk_rec(CLS_DOT, '0, pv_off_d, PosOne, pv_line_d,
                                         pv_col_d, 1'b0, '0);
                nres = nres + 3'd1;
              end
              M_STR, M_STRQ, M_QID: begin
                recs[nres[1:0]] = mk_rec((mode_d == M_QID) ? CLS_IDENT : CLS_STR, '0,
                                         ts_off_d, tlen_d, ts_line_d, ts_col_d, esc_d, '0);
                nres = nres + 3'd1;
              end
              M_BANG: begin
                recs[nres[1:0]] = mk_rec(CLS_ERR, '0, ts_off_d, PosOne, ts_line_d,
                                         ts_col_d, 1'b0, "!");
                nres = nres + 3'd1;
                halt_d = 1'b1;
              end
              default: ;
            endcase
          end
          if (!halt_d) begin
            recs[nres[1:0]] = mk_rec(CLS_EOF, '0, off_d, '0, line_d, col_d, 1'b0, '0);
            nres = nres + 3'd1;
          end
          mode_d = M_IDLE; off_d = '0; line_d = PosOne; col_d = PosOne;
          ts_off_d = '0; ts_line_d = PosOne; ts_col_d = PosOne; tlen_d = '0;
          esc_d = 1'b0; halt_d = 1'b0;
          pv_off_d = '0; pv_line_d = PosOne; pv_col_d = PosOne;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      off_q     <= '0;
      line_q    <= PosOne;
      col_q     <= PosOne;
      ts_off_q  <= '0;
      ts_line_q <= PosOne;
      ts_col_q  <= PosOne;
      tlen_q    <= '0;
      pv_off_q  <= '0;
      pv_line_q <= PosOne;
      pv_col_q  <= PosOne;
      esc_q     <= 1'b0;
      halt_q    <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      off_q     <= off_d;
      line_q    <= line_d;
      col_q     <= col_d;
      ts_off_q  <= ts_off_d;
      ts_line_q <= ts_line_d;
      ts_col_q  <= ts_col_d;
      tlen_q    <= tlen_d;
      pv_off_q  <= pv_off_d;
      pv_line_q <= pv_line_d;
      pv_col_q  <= pv_col_d;
      esc_q     <= esc_d;
      halt_q    <= halt_d;
    end
  end

  // word key, valid only while a word is pending
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  sts_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .cnt_i   (nres),
    .recs_i  (recs),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rec_o   (orec),
    .last_o  (olast)
  );

  assign token_class_o   = orec.cls;
  assign keyword_index_o = orec.kw;
  assign start_offset_o  = orec.off;
  assign token_length_o  = orec.len;
  assign start_line_o    = orec.line;
  assign start_column_o  = orec.col;
  assign has_escape_o    = orec.esc;
  assign bad_char_o      = orec.bad;
  assign run_end_o       = olast;

endmodule

`default_nettype wire

### bench/sql_token_scanner_checker.sv
// ---------------------------------------------------------------------------
// sql_token_scanner_checker
// Watches both channels of the token scanner, predicts the token records of
// every accepted byte and compares each record leaving the block with them.
// ---------------------------------------------------------------------------
`default_nettype none

module sql_token_scanner_checker
  import sts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        text_end_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [4:0]  token_class_i,
  input  wire logic [6:0]  keyword_index_i,
  input  wire logic [15:0] start_offset_i,
  input  wire logic [15:0] token_length_i,
  input  wire logic [15:0] start_line_i,
  input  wire logic [15:0] start_column_i,
  input  wire logic        has_escape_i,
  input  wire logic [7:0]  bad_char_i,
  input  wire logic        run_end_i,
  output int               mismatch_count_o,
  output int               pending_count_o
);

  localparam int POS_MAX = 65535;

  typedef enum int {
    SM_IDLE, SM_MINUS, SM_COMMENT, SM_IDENT, SM_INT, SM_INTDOT, SM_DEC,
    SM_STR, SM_STRQ, SM_QID, SM_LT, SM_GT, SM_BANG
  } scan_mode_e;

  typedef struct {
    tok_rec_t rec;
    logic     last;
  } token_item_t;

  token_item_t token_fifo[$];
  token_item_t byte_recs[$];

  scan_mode_e     mode;
  int             cur_off, cur_line, cur_col;
  int             t_off, t_line, t_col, t_len;
  int             p_off, p_line, p_col;
  logic [7:0]     word_chars[KW_LEN_MAX];
  logic           esc_seen, halted;

  assign pending_count_o = token_fifo.size();

  function automatic int sat_add(int v, int a);
    return (v + a > POS_MAX) ? POS_MAX : v + a;
  endfunction

  function automatic logic blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void clear_scan();
    mode = SM_IDLE;
    cur_off = 0; cur_line = 1; cur_col = 1;
    t_off = 0; t_line = 1; t_col = 1; t_len = 0;
    esc_seen = 0; halted = 0;
    p_off = 0; p_line = 1; p_col = 1;
  endfunction

  function automatic void add_rec(tok_class_e cls, int kw, int off, int len, int line,
                                  int col, logic esc, logic [7:0] bad);
    token_item_t it;
    if (byte_recs.size() >= RES_MAX) return;
    it.rec.cls = cls; it.rec.kw = 7'(kw); it.rec.off = 16'(off); it.rec.len = 16'(len);
    it.rec.line = 16'(line); it.rec.col = 16'(col); it.rec.esc = esc; it.rec.bad = bad;
    it.last = 1'b0;
    byte_recs = {byte_recs, it};
  endfunction

  function automatic void add_tok(tok_class_e cls, int kw);
    add_rec(cls, kw, t_off, t_len, t_line, t_col, esc_seen, 8'd0);
  endfunction

  function automatic void open_tok(int off, int line, int col);
    t_off = off; t_line = line; t_col = col; t_len = 0; esc_seen = 0;
  endfunction

  function automatic void close_word();
    logic [KEY_BITS-1:0] key;
    int kw;
    key = '0;
    kw = 0;
    if (t_len >= 1 && t_len <= KW_LEN_MAX) begin
      for (int i = 0; i < t_len; i++) key = {key[KEY_BITS-9:0], word_chars[i]};
      for (int i = 0; i < KW_COUNT; i++) if (key == KW_WORDS[i]) kw = i + 1;
    end
    add_tok(kw != 0 ? CLS_KW : CLS_IDENT, kw);
  endfunction

  function automatic void grow_word(logic [7:0] c);
    if (t_len < KW_LEN_MAX) word_chars[t_len] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    t_len = sat_add(t_len, 1);
  endfunction

  function automatic void single(tok_class_e cls, int off, int line, int col);
    add_rec(cls, 0, off, 1, line, col, 1'b0, 8'd0);
  endfunction

  function automatic void bang_fail();
    add_rec(CLS_ERR, 0, t_off, 1, t_line, t_col, 1'b0, "!");
    halted = 1;
    mode = SM_IDLE;
  endfunction

  function automatic void pair(tok_class_e cls);
    t_len = 2;
    add_tok(cls, 0);
    mode = SM_IDLE;
  endfunction

  function automatic void fresh(logic [7:0] c, int off, int line, int col);
    mode = SM_IDLE;
    if (blank(c)) return;
    if (letter(c) || c == "_") begin
      open_tok(off, line, col); grow_word(c); mode = SM_IDENT; return;
    end
    if (numeral(c)) begin
      open_tok(off, line, col); t_len = 1; mode = SM_INT; return;
    end
    case (c)
      "'": begin open_tok(sat_add(off, 1), line, col); mode = SM_STR; end
      "\"": begin open_tok(sat_add(off, 1), line, col); mode = SM_QID; end
      "-": begin open_tok(off, line, col); mode = SM_MINUS; end
      "<": begin open_tok(off, line, col); mode = SM_LT; end
      ">": begin open_tok(off, line, col); mode = SM_GT; end
      "!": begin open_tok(off, line, col); mode = SM_BANG; end
      "(": single(CLS_LPAREN, off, line, col);
      ")": single(CLS_RPAREN, off, line, col);
      ",": single(CLS_COMMA, off, line, col);
      ";": single(CLS_SEMI, off, line, col);
      ".": single(CLS_DOT, off, line, col);
      "+": single(CLS_PLUS, off, line, col);
      "*": single(CLS_STAR, off, line, col);
      "/": single(CLS_SLASH, off, line, col);
      "%": single(CLS_PCT, off, line, col);
      "=": single(CLS_EQ, off, line, col);
      default: begin
        add_rec(CLS_ERR, 0, off, 1, line, col, 1'b0, c);
        halted = 1;
      end
    endcase
  endfunction

  function automatic void flush_tok();
    case (mode)
      SM_MINUS: begin t_len = 1; add_tok(CLS_MINUS, 0); end
      SM_IDENT: close_word();
      SM_INT: add_tok(CLS_INT, 0);
      SM_INTDOT: begin add_tok(CLS_INT, 0); single(CLS_DOT, p_off, p_line, p_col); end
      SM_DEC: add_tok(CLS_DEC, 0);
      SM_STR, SM_STRQ: add_tok(CLS_STR, 0);
      SM_QID: add_tok(CLS_IDENT, 0);
      SM_LT: begin t_len = 1; add_tok(CLS_LT, 0); end
      SM_GT: begin t_len = 1; add_tok(CLS_GT, 0); end
      SM_BANG: bang_fail();
      default: ;
    endcase
    mode = SM_IDLE;
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic last);
    int off, line, col;
    off = cur_off; line = cur_line; col = cur_col;
    byte_recs.delete();
    if (halted) begin
      if (last) clear_scan();
      return;
    end
    case (mode)
      SM_MINUS:
        if (c == "-") mode = SM_COMMENT;
        else begin t_len = 1; add_tok(CLS_MINUS, 0); fresh(c, off, line, col); end
      SM_COMMENT: if (c == 8'd10) mode = SM_IDLE;
      SM_IDENT:
        if (letter(c) || numeral(c) || c == "_") grow_word(c);
        else begin close_word(); fresh(c, off, line, col); end
      SM_INT:
        if (numeral(c)) t_len = sat_add(t_len, 1);
        else if (c == ".") mode = SM_INTDOT;
        else begin add_tok(CLS_INT, 0); fresh(c, off, line, col); end
      SM_INTDOT:
        if (numeral(c)) begin t_len = sat_add(t_len, 2); mode = SM_DEC; end
        else begin
          add_tok(CLS_INT, 0);
          single(CLS_DOT, p_off, p_line, p_col);
          fresh(c, off, line, col);
        end
      SM_DEC:
        if (numeral(c)) t_len = sat_add(t_len, 1);
        else begin add_tok(CLS_DEC, 0); fresh(c, off, line, col); end
      SM_STR:
        if (c == "'") mode = SM_STRQ;
        else t_len = sat_add(t_len, 1);
      SM_STRQ:
        if (c == "'") begin t_len = sat_add(t_len, 2); esc_seen = 1; mode = SM_STR; end
        else begin add_tok(CLS_STR, 0); fresh(c, off, line, col); end
      SM_QID:
        if (c == "\"") begin add_tok(CLS_IDENT, 0); mode = SM_IDLE; end
        else t_len = sat_add(t_len, 1);
      SM_LT:
        if (c == "=") pair(CLS_LE);
        else if (c == ">") pair(CLS_NE);
        else begin t_len = 1; add_tok(CLS_LT, 0); fresh(c, off, line, col); end
      SM_GT:
        if (c == "=") pair(CLS_GE);
        else begin t_len = 1; add_tok(CLS_GT, 0); fresh(c, off, line, col); end
      SM_BANG:
        if (c == "=") pair(CLS_NE);
        else bang_fail();
      default: fresh(c, off, line, col);
    endcase
    p_off = off; p_line = line; p_col = col;
    cur_off = sat_add(cur_off, 1);
    if (c == 8'd10) begin cur_line = sat_add(cur_line, 1); cur_col = 1; end
    else cur_col = sat_add(cur_col, 1);
    if (last) begin
      if (!halted) flush_tok();
      if (!halted) add_rec(CLS_EOF, 0, cur_off, 0, cur_line, cur_col, 1'b0, 8'd0);
      clear_scan();
    end
    if (byte_recs.size() > 0) byte_recs[byte_recs.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count_o++;
  endtask

  initial begin
    mismatch_count_o = 0;
    clear_scan();
  end

  always @(posedge clk_i) begin
    token_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (token_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected record class %0d", token_class_i));
        end else begin
          want = token_fifo.pop_front();
          if (token_class_i !== want.rec.cls)
            report_mismatch($sformatf("class %0d want %0d", token_class_i, want.rec.cls));
          if (keyword_index_i !== want.rec.kw)
            report_mismatch($sformatf("keyword %0d want %0d", keyword_index_i, want.rec.kw));
          if (start_offset_i !== want.rec.off)
            report_mismatch($sformatf("offset %0d want %0d", start_offset_i, want.rec.off));
          if (token_length_i !== want.rec.len)
            report_mismatch($sformatf("length %0d want %0d", token_length_i, want.rec.len));
          if (start_line_i !== want.rec.line)
            report_mismatch($sformatf("line %0d want %0d", start_line_i, want.rec.line));
          if (start_column_i !== want.rec.col)
            report_mismatch($sformatf("column %0d want %0d", start_column_i, want.rec.col));
          if (has_escape_i !== want.rec.esc)
            report_mismatch($sformatf("escape %0b want %0b", has_escape_i, want.rec.esc));
          if (bad_char_i !== want.rec.bad)
            report_mismatch($sformatf("bad char %0h want %0h", bad_char_i, want.rec.bad));
          if (run_end_i !== want.last)
            report_mismatch($sformatf("run end %0b want %0b", run_end_i, want.last));
        end
      end
      if (in_valid_i && in_ready_i) begin
        scan_byte(char_in_i, text_end_i);
        foreach (byte_recs[i]) token_fifo = {token_fifo, byte_recs[i]};
      end
    end
  end

endmodule

`default_nettype wire

### bench/sql_token_scanner_core_tb.sv
// ---------------------------------------------------------------------------
// sql_token_scanner_core_tb
// Feeds the token scanner directed and random query text under varying
// sender gaps and receiver stalls; the checker predicts and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module sql_token_scanner_core_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_in_i = 8'd0;
  logic        text_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [4:0]  token_class_o;
  logic [6:0]  keyword_index_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [15:0] start_line_o;
  logic [15:0] start_column_o;
  logic        has_escape_o;
  logic [7:0]  bad_char_o;
  logic        run_end_o;
  int          mismatch_count;
  int          pending_count;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          bytes_sent = 0;

  always #4 clk_i = ~clk_i;

  sql_token_scanner_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .char_in_i, .text_end_i,
    .out_valid_o, .out_ready_i, .token_class_o, .keyword_index_o, .start_offset_o,
    .token_length_o, .start_line_o, .start_column_o, .has_escape_o, .bad_char_o,
    .run_end_o
  );

  sql_token_scanner_checker checker_u (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .char_in_i, .text_end_i,
    .out_valid_i(out_valid_o), .out_ready_i, .token_class_i(token_class_o),
    .keyword_index_i(keyword_index_o), .start_offset_i(start_offset_o),
    .token_length_i(token_length_o), .start_line_i(start_line_o),
    .start_column_i(start_column_o), .has_escape_i(has_escape_o),
    .bad_char_i(bad_char_o), .run_end_i(run_end_o),
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  task automatic send_byte(logic [7:0] c, logic last);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    text_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_query(string q);
    for (int i = 0; i < q.len(); i++) send_byte(q[i], i == q.len() - 1);
  endtask

  function automatic string rand_case(string w);
    string s;
    s = w;
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(1) && s[i] >= "A" && s[i] <= "Z") s[i] = s[i] + 8'd32;
    return s;
  endfunction

  function automatic string rand_from(string set, int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, set[$urandom_range(set.len() - 1)]};
    return s;
  endfunction

  function automatic string rand_token();
    string kws[8] = '{"SELECT", "FROM", "WHERE", "SUBSTRING", "COALESCE", "FORMAT",
                      "AS", "INDEXES"};
    string ops[14] = '{"(", ")", ",", ";", ".", "+", "-", "*", "/", "%", "=", "<=",
                       "<>", "!="};
    string cmp[3] = '{"<", ">", ">="};
    string az, dg;
    az = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    dg = "0123456789";
    case ($urandom_range(11))
      0, 1: return rand_case(kws[$urandom_range(7)]);
      2: return {rand_from(az, 1), rand_from({az, dg}, $urandom_range(12))};
      3: return rand_from(dg, $urandom_range(4, 1));
      4: return {rand_from(dg, $urandom_range(3, 1)), ".", rand_from(dg, $urandom_range(3, 1))};
      5: return {"'", rand_from({az, " ''"}, $urandom_range(6)), "'"};
      6: return {"\"", rand_from(az, $urandom_range(5)), "\""};
      7: return {"--", rand_from({az, " "}, $urandom_range(6)), "\n"};
      8: return cmp[$urandom_range(2)];
      9: return {rand_from(dg, 2), ".", rand_from(az, 1)};
      default: return ops[$urandom_range(13)];
    endcase
  endfunction

  function automatic string rand_query();
    string q, seps;
    seps = " \t\n\r\v\f";
    q = "";
    if ($urandom_range(9) == 0) begin
      for (int i = 0; i < $urandom_range(12, 2); i++) q = {q, 8'($urandom_range(255))};
      return q;
    end
    for (int i = 0; i < $urandom_range(8, 2); i++) begin
      q = {q, rand_token()};
      if ($urandom_range(3) != 0) q = {q, rand_from(seps, 1)};
    end
    if ($urandom_range(9) == 0) q = {q, 8'($urandom_range(255, 128)), "x y"};
    return q;
  endfunction

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase_gap[4] = '{0, 47, 0, 21};
    int phase_stall[4] = '{0, 0, 47, 21};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed text: keywords, long words, numbers, strings, operators, errors
    send_query("SELECT a,b FROM t WHERE x<=1;");
    send_query("select Substring substrings coalesce\n-- note\nformat _q9");
    send_query("12.5 3. 7.x 0 'it''s' \"Id\" <> != >= > < - + * / % =");
    send_query("'open");
    send_query("\"open");
    send_query("12.");
    send_query("a -");
    send_query("a ! b");
    send_query("x @ y");
    send_query({"q ", 8'hff, " z"});
    send_query("!");
    send_byte(8'h00, 1'b1);
    send_query("--");

    for (int p = 0; p < 4; p++) begin
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      while (bytes_sent < 170 + 50 * (p + 1)) send_query(rand_query());
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
